// ----- hdl/thdtal_pkg.sv -----
// ----------------------------------------------------------------------------
// thdtal_pkg
// Shared codes and types for the tap/hold/double-tap axis lock.
// ----------------------------------------------------------------------------
package thdtal_pkg;

  localparam logic [1:0] CMD_MOTION  = 2'd0;
  localparam logic [1:0] CMD_PRESS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [1:0] LOCK_Y_ONLY = 2'd0;
  localparam logic [1:0] LOCK_X_ONLY = 2'd1;
  localparam logic [1:0] LOCK_FREE   = 2'd2;

  localparam logic [15:0] TERM_RESET = 16'd200;

  // register index of tapping_term
  localparam logic REG_TAPPING_TERM = 1'b0;

  // lock status after an item's update
  typedef struct packed {
    logic base_horizontal;
    logic momentary_swap;
    logic both_unlocked;
  } lock_stat_t;

endpackage

// ----- hdl/thdtal_key_fsm.sv -----
// ----------------------------------------------------------------------------
// thdtal_key_fsm
// Tap/hold/double-tap detector with hold and tap countdown timers.
// ----------------------------------------------------------------------------
module thdtal_key_fsm #(
  parameter int TIMER_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [1:0]               cmd,
  input  logic [15:0]              term,
  output thdtal_pkg::lock_stat_t   stat_nxt
);
  import thdtal_pkg::*;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic                  base_horizontal_r, base_horizontal_nxt;
  logic                  momentary_swap_r, momentary_swap_nxt;
  logic                  both_unlocked_r, both_unlocked_nxt;
  logic                  key_held_r, key_held_nxt;
  logic                  hold_decided_r, hold_decided_nxt;
  logic                  tap_pending_r, tap_pending_nxt;
  logic                  double_press_r, double_press_nxt;
  logic [TIMER_BITS-1:0] hold_timer_r, hold_timer_nxt;
  logic [TIMER_BITS-1:0] tap_timer_r, tap_timer_nxt;
  logic [TIMER_BITS-1:0] load;

  // saturate to the timer width, a zero term loads as one
  always_comb begin
    if (33'(term) > TMAX) begin
      load = '1;
    end else if (term == 16'd0) begin
      load = TIMER_BITS'(1);
    end else begin
      load = TIMER_BITS'(term);
    end
  end

  always_comb begin
    base_horizontal_nxt = base_horizontal_r;
    momentary_swap_nxt  = momentary_swap_r;
    both_unlocked_nxt   = both_unlocked_r;
    key_held_nxt        = key_held_r;
    hold_decided_nxt    = hold_decided_r;
    tap_pending_nxt     = tap_pending_r;
    double_press_nxt    = double_press_r;
    hold_timer_nxt      = hold_timer_r;
    tap_timer_nxt       = tap_timer_r;
    unique case (cmd)
      CMD_PRESS: begin
        key_held_nxt     = 1'b1;
        hold_decided_nxt = 1'b0;
        if (tap_pending_r) begin
          tap_timer_nxt    = '0;
          tap_pending_nxt  = 1'b0;
          double_press_nxt = 1'b1;
        end else begin
          double_press_nxt = 1'b0;
          hold_timer_nxt   = load;
        end
      end
      CMD_RELEASE: begin
        hold_timer_nxt = '0;
        key_held_nxt   = 1'b0;
        if (double_press_r) begin
          double_press_nxt   = 1'b0;
          hold_decided_nxt   = 1'b0;
          both_unlocked_nxt  = 1'b1;
          momentary_swap_nxt = 1'b0;
        end else if (hold_decided_r) begin
          momentary_swap_nxt = 1'b0;
          hold_decided_nxt   = 1'b0;
        end else begin
          tap_pending_nxt = 1'b1;
          tap_timer_nxt   = load;
        end
      end
      CMD_TICK: begin
        // hold timer resolves first, it may cancel the pending tap
        if (hold_timer_r != '0) begin
          hold_timer_nxt = hold_timer_r - TIMER_BITS'(1);
          if (hold_timer_nxt == '0 && key_held_r && !hold_decided_r && !double_press_r) begin
            hold_decided_nxt   = 1'b1;
            tap_pending_nxt    = 1'b0;
            momentary_swap_nxt = 1'b1;
          end
        end
        if (tap_timer_r != '0) begin
          tap_timer_nxt = tap_timer_r - TIMER_BITS'(1);
          if (tap_timer_nxt == '0 && tap_pending_nxt) begin
            tap_pending_nxt = 1'b0;
            if (both_unlocked_r) begin
              both_unlocked_nxt = 1'b0;
            end else begin
              base_horizontal_nxt = !base_horizontal_r;
            end
          end
        end
      end
      CMD_MOTION: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_horizontal_r <= 1'b0;
      momentary_swap_r  <= 1'b0;
      both_unlocked_r   <= 1'b0;
      key_held_r        <= 1'b0;
      hold_decided_r    <= 1'b0;
      tap_pending_r     <= 1'b0;
      double_press_r    <= 1'b0;
      hold_timer_r      <= '0;
      tap_timer_r       <= '0;
    end else if (en) begin
      base_horizontal_r <= base_horizontal_nxt;
      momentary_swap_r  <= momentary_swap_nxt;
      both_unlocked_r   <= both_unlocked_nxt;
      key_held_r        <= key_held_nxt;
      hold_decided_r    <= hold_decided_nxt;
      tap_pending_r     <= tap_pending_nxt;
      double_press_r    <= double_press_nxt;
      hold_timer_r      <= hold_timer_nxt;
      tap_timer_r       <= tap_timer_nxt;
    end
  end

  assign stat_nxt.base_horizontal = base_horizontal_nxt;
  assign stat_nxt.momentary_swap  = momentary_swap_nxt;
  assign stat_nxt.both_unlocked   = both_unlocked_nxt;

endmodule

// ----- hdl/thdtal_motion_filter.sv -----
// ----------------------------------------------------------------------------
// thdtal_motion_filter
// Zeroes relative motion on the blocked axis and all non-motion items, and forms the lock status.
// ----------------------------------------------------------------------------
module thdtal_motion_filter (
  input  logic                   [1:0]  cmd,
  input  logic                          is_relative,
  input  logic                   [1:0]  axis,
  input  logic signed            [15:0] move_value,
  input  logic                          sync_in,
  input  thdtal_pkg::lock_stat_t        stat,
  output logic signed            [15:0] value_out,
  output logic                          sync_out,
  output logic                   [1:0]  lock_mode,
  output logic                          hold_active
);
  import thdtal_pkg::*;

  logic horiz;
  logic free;
  logic blocked;

  assign horiz = stat.momentary_swap ^ stat.base_horizontal;
  assign free  = stat.both_unlocked && !stat.momentary_swap;

  always_comb begin
    blocked = 1'b0;
    if (is_relative && !free) begin
      blocked = horiz ? (axis == AXIS_Y) : (axis == AXIS_X);
    end
  end

  always_comb begin
    if (cmd != CMD_MOTION || blocked) begin
      value_out = '0;
      sync_out  = 1'b0;
    end else begin
      value_out = move_value;
      sync_out  = sync_in;
    end
  end

  assign lock_mode   = free ? LOCK_FREE : (horiz ? LOCK_X_ONLY : LOCK_Y_ONLY);
  assign hold_active = stat.momentary_swap;

endmodule

// ----- hdl/tap_hold_double_tap_axis_lock.sv -----
// ----------------------------------------------------------------------------
// tap_hold_double_tap_axis_lock
// Axis lock for relative motion, steered by a tap/hold/double-tap key.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while in_stall is low, and its result appears in the output
// register in the following cycle; the key detector and its two timers update in
// the cycle of acceptance, so consecutive items need no gap. Input stall
// follows output stall only while a result is waiting. tapping_term sits at
// byte address 0 of the register port and resets to 200 ticks.
module tap_hold_double_tap_axis_lock #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic               in_is_relative,
  input  logic [1:0]         in_axis,
  input  logic signed [15:0] in_move_value,
  input  logic               in_sync_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_value_out,
  output logic               out_sync_out,
  output logic [1:0]         out_lock_mode,
  output logic               out_hold_active,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import thdtal_pkg::*;

  logic               accept;
  logic [15:0]        term_r;
  lock_stat_t         stat_nxt;
  logic signed [15:0] value_c;
  logic               sync_c;
  logic [1:0]         lock_c;
  logic               hold_c;
  logic               out_valid_r;
  logic signed [15:0] value_r;
  logic               sync_r;
  logic [1:0]         lock_r;
  logic               hold_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TAPPING_TERM) ? {16'd0, term_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= TERM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TAPPING_TERM) begin
      term_r <= pwdata[15:0];
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  thdtal_key_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (accept),
    .cmd      (in_command),
    .term     (term_r),
    .stat_nxt (stat_nxt)
  );

  thdtal_motion_filter u_filt (
    .cmd         (in_command),
    .is_relative (in_is_relative),
    .axis        (in_axis),
    .move_value  (in_move_value),
    .sync_in     (in_sync_in),
    .stat        (stat_nxt),
    .value_out   (value_c),
    .sync_out    (sync_c),
    .lock_mode   (lock_c),
    .hold_active (hold_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= value_c;
      sync_r  <= sync_c;
      lock_r  <= lock_c;
      hold_r  <= hold_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_out   = value_r;
  assign out_sync_out    = sync_r;
  assign out_lock_mode   = lock_r;
  assign out_hold_active = hold_r;

endmodule

// ----- hdl/thdtal_checker.sv -----
// ----------------------------------------------------------------------------
// thdtal_checker
// Port-level checks for the axis lock, bound to the top level.
// ----------------------------------------------------------------------------
module thdtal_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_value_out,
  input logic               out_sync_out,
  input logic [1:0]         out_lock_mode,
  input logic               out_hold_active
);
  import thdtal_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_out) && $stable(out_sync_out)
      && $stable(out_lock_mode) && $stable(out_hold_active))
    else $error("stalled result changed");

  // key and tick items carry no motion
  a_nonmotion_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command != CMD_MOTION
      |=> out_valid && out_value_out == 16'sd0 && !out_sync_out)
    else $error("non-motion item gave motion");

  // an active swap always shows a single-axis lock
  a_free_no_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_active |-> out_lock_mode != LOCK_FREE)
    else $error("free lock with swap active");

  a_lock_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lock_mode == LOCK_Y_ONLY || out_lock_mode == LOCK_X_ONLY
      || out_lock_mode == LOCK_FREE)
    else $error("bad lock code");

endmodule

bind tap_hold_double_tap_axis_lock thdtal_checker u_thdtal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value_out   (out_value_out),
  .out_sync_out    (out_sync_out),
  .out_lock_mode   (out_lock_mode),
  .out_hold_active (out_hold_active)
);

// ----- dv/axis_lock_checker.sv -----
// ----------------------------------------------------------------------------
// axis_lock_checker
// Watches the item channels and the register port of the axis lock, keeps
// its own copy of the key detector and lock state, and compares every
// result with the predicted filtered motion and lock status.
// ----------------------------------------------------------------------------
module axis_lock_checker
  import thdtal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_is_relative,
  input  logic [1:0]  in_axis,
  input  logic [15:0] in_move_value,
  input  logic        in_sync_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_value_out,
  input  logic        out_sync_out,
  input  logic [1:0]  out_lock_mode,
  input  logic        out_hold_active,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] value;
    logic        sync;
    logic [1:0]  lock;
    logic        hold;
  } motion_res_t;

  localparam logic [2:0] TERM_ADDR  = {REG_TAPPING_TERM, 2'b00};
  localparam int         SHOW_LIMIT = 10;

  logic [15:0] term;
  logic        base_h, swap, unlocked, held, decided, tap_wait, dbl;
  logic [15:0] hold_cnt, tap_cnt;
  motion_res_t filtered_q[$];
  int          fail_tally;
  int          result_idx;

  function automatic logic [15:0] term_load(input logic [15:0] t);
    return (t == 16'd0) ? 16'd1 : t;
  endfunction

  task automatic note_failure(input string what);
    fail_tally++;
    if (fail_tally <= SHOW_LIMIT) $display("ERROR: %s", what);
  endtask

  task automatic commit_tap();
    if (unlocked) unlocked = 1'b0;
    else base_h = ~base_h;
  endtask

  task automatic step_lock(input logic [1:0] cmd, input logic rel, input logic [1:0] ax,
                           input logic [15:0] val, input logic sy, output motion_res_t r);
    logic horiz;
    logic free_both;
    logic blocked;
    case (cmd)
      CMD_PRESS: begin
        held    = 1'b1;
        decided = 1'b0;
        if (tap_wait) begin
          // second press inside the tap window
          tap_cnt  = '0;
          tap_wait = 1'b0;
          dbl      = 1'b1;
        end else begin
          dbl      = 1'b0;
          hold_cnt = term_load(term);
        end
      end
      CMD_RELEASE: begin
        hold_cnt = '0;
        held     = 1'b0;
        if (dbl) begin
          dbl      = 1'b0;
          decided  = 1'b0;
          unlocked = 1'b1;
          swap     = 1'b0;
        end else if (decided) begin
          swap    = 1'b0;
          decided = 1'b0;
        end else begin
          tap_wait = 1'b1;
          tap_cnt  = term_load(term);
        end
      end
      CMD_TICK: begin
        // hold timer is serviced first, it may cancel a pending tap
        if (hold_cnt != '0) begin
          hold_cnt = hold_cnt - 16'd1;
          if (hold_cnt == '0 && held && !decided && !dbl) begin
            decided  = 1'b1;
            tap_wait = 1'b0;
            swap     = 1'b1;
          end
        end
        if (tap_cnt != '0) begin
          tap_cnt = tap_cnt - 16'd1;
          if (tap_cnt == '0 && tap_wait) begin
            tap_wait = 1'b0;
            commit_tap();
          end
        end
      end
      default: ;
    endcase
    horiz     = swap ^ base_h;
    free_both = unlocked & ~swap;
    r.value   = val;
    r.sync    = sy;
    if (cmd != CMD_MOTION) begin
      r.value = '0;
      r.sync  = 1'b0;
    end else if (rel && !free_both) begin
      blocked = horiz ? (ax == AXIS_Y) : (ax == AXIS_X);
      if (blocked) begin
        r.value = '0;
        r.sync  = 1'b0;
      end
    end
    r.lock = free_both ? LOCK_FREE : (horiz ? LOCK_X_ONLY : LOCK_Y_ONLY);
    r.hold = swap;
  endtask

  always @(posedge clk) begin : monitor
    motion_res_t want;
    motion_res_t got;
    if (!rst_n) begin
      term       = TERM_RESET;
      base_h     = 1'b0;
      swap       = 1'b0;
      unlocked   = 1'b0;
      held       = 1'b0;
      decided    = 1'b0;
      tap_wait   = 1'b0;
      dbl        = 1'b0;
      hold_cnt   = '0;
      tap_cnt    = '0;
      fail_tally = 0;
      result_idx = 0;
      filtered_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pready && paddr == TERM_ADDR) begin
        if (pwrite) term = pwdata[15:0];
        else if (prdata[15:0] !== term)
          note_failure($sformatf("tapping_term read %0h, expected %0h", prdata[15:0], term));
      end
      if (out_valid && !out_stall) begin
        got = '{out_value_out, out_sync_out, out_lock_mode, out_hold_active};
        if (filtered_q.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = filtered_q.pop_front();
          if (got !== want)
            note_failure($sformatf({"result %0d: value %0d/%0d sync %0b/%0b lock %0d/%0d ",
                                    "hold %0b/%0b (expected/actual)"}, result_idx,
                                   $signed(want.value), $signed(got.value), want.sync, got.sync,
                                   want.lock, got.lock, want.hold, got.hold));
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        step_lock(in_command, in_is_relative, in_axis, in_move_value, in_sync_in, want);
        filtered_q.push_back(want);
      end
      pending    <= filtered_q.size();
      fail_count <= fail_tally;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the tap/hold/double-tap axis lock with directed key and motion
// items, then with random taps, holds, double taps, motion and noise over a
// range of tapping terms, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import thdtal_pkg::*;

  localparam logic [2:0] TERM_ADDR = {REG_TAPPING_TERM, 2'b00};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic               in_is_relative;
  logic [1:0]         in_axis;
  logic signed [15:0] in_move_value;
  logic               in_sync_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_value_out;
  logic               out_sync_out;
  logic [1:0]         out_lock_mode;
  logic               out_hold_active;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  int                 cur_term;
  bit                 steady;
  int                 sent_total;
  int                 sent_by_cmd[4];
  int                 n_terms;

  tap_hold_double_tap_axis_lock i_dut (.*);

  axis_lock_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic rel, input logic [1:0] ax,
                           input logic [15:0] val, input logic sy);
    int gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_is_relative <= rel;
    in_axis        <= ax;
    in_move_value  <= val;
    in_sync_in     <= sy;
    do @(posedge clk); while (in_stall);
    sent_total++;
    sent_by_cmd[cmd]++;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // key and tick items carry random payload, which the block ignores
  task automatic send_key(input logic [1:0] cmd);
    send_item(cmd, 1'($urandom), 2'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_key(CMD_TICK);
  endtask

  task automatic send_motions(input int n);
    logic [15:0] val;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       val = 16'h7fff;
        1:       val = 16'h8000;
        2:       val = 16'h0000;
        3:       val = 16'hffff;
        default: val = 16'($urandom);
      endcase
      send_item(CMD_MOTION, $urandom_range(0, 4) != 0, 2'($urandom_range(0, 3)), val,
                1'($urandom));
    end
  endtask

  task automatic apb_access(input logic wr, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TERM_ADDR;
    pwdata  <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // only while idle: every expected result has been seen
  task automatic set_term(input logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    apb_access(1'b1, v);
    apb_access(1'b0, 16'd0);
    cur_term = v;
    n_terms++;
  endtask

  task automatic run_mix(input int n);
    int stop;
    int te;
    stop = sent_total + n;
    te   = (cur_term == 0) ? 1 : cur_term;
    while (sent_total < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // tap: release before the term, then tick around the term so the tap may commit
          send_key(CMD_PRESS);
          send_motions($urandom_range(0, 2));
          send_ticks($urandom_range(0, te - 1));
          send_key(CMD_RELEASE);
          send_motions($urandom_range(0, 2));
          send_ticks(te - 1 + $urandom_range(0, 2));
        end
        3, 4: begin
          send_key(CMD_PRESS);
          send_ticks(te - 1 + $urandom_range(0, 2));
          send_motions($urandom_range(1, 3));
          send_key(CMD_RELEASE);
          send_motions($urandom_range(0, 2));
        end
        5, 6: begin
          send_key(CMD_PRESS);
          send_ticks($urandom_range(0, te - 1));
          send_key(CMD_RELEASE);
          send_motions($urandom_range(0, 1));
          send_ticks($urandom_range(0, te - 1));
          send_key(CMD_PRESS);
          send_motions($urandom_range(0, 2));
          send_ticks($urandom_range(0, te + 1));
          send_key(CMD_RELEASE);
          send_motions($urandom_range(0, 2));
        end
        7: begin
          repeat ($urandom_range(1, 6))
            send_item(2'($urandom), 1'($urandom), 2'($urandom), 16'($urandom), 1'($urandom));
        end
        default: send_motions($urandom_range(1, 6));
      endcase
    end
  endtask

  // receiver: random stall before each result
  initial begin
    int gap;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int plan[8];
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_MOTION;
    in_is_relative <= 1'b0;
    in_axis        <= AXIS_X;
    in_move_value  <= '0;
    in_sync_in     <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cur_term       = TERM_RESET;
    steady         = 1'b0;
    sent_total     = 0;
    n_terms        = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset term, release with no press, motion extremes
    apb_access(1'b0, 16'd0);
    send_key(CMD_RELEASE);
    send_item(CMD_MOTION, 1'b1, AXIS_X, 16'h7fff, 1'b1);
    send_item(CMD_MOTION, 1'b1, AXIS_Y, 16'h8000, 1'b1);
    send_item(CMD_MOTION, 1'b0, AXIS_X, 16'h8000, 1'b1);
    send_item(CMD_MOTION, 1'b1, 2'd2, 16'h7fff, 1'b1);
    send_item(CMD_MOTION, 1'b1, 2'd3, 16'hffff, 1'b0);
    set_term(16'd1);
    // press inside the open tap window: double tap unlocks
    send_key(CMD_PRESS);
    send_key(CMD_RELEASE);
    send_item(CMD_MOTION, 1'b1, AXIS_X, 16'h7fff, 1'b1);
    // hold while unlocked swaps to X only
    send_key(CMD_PRESS);
    send_key(CMD_TICK);
    send_item(CMD_MOTION, 1'b1, AXIS_Y, 16'hffff, 1'b1);
    send_key(CMD_RELEASE);
    // tap re-locks, second tap toggles to horizontal
    send_key(CMD_PRESS);
    send_key(CMD_RELEASE);
    send_key(CMD_TICK);
    send_key(CMD_PRESS);
    send_key(CMD_RELEASE);
    send_key(CMD_TICK);
    send_item(CMD_MOTION, 1'b1, AXIS_Y, 16'h7fff, 1'b1);
    // press while already held
    send_key(CMD_PRESS);
    send_key(CMD_PRESS);
    send_key(CMD_TICK);
    send_key(CMD_RELEASE);
    set_term(16'd0);
    send_key(CMD_PRESS);
    send_key(CMD_TICK);
    send_item(CMD_MOTION, 1'b1, AXIS_X, 16'h8000, 1'b1);
    send_key(CMD_RELEASE);

    plan = '{1, 2, 3, 5, 8, 0, 13, $urandom_range(1, 16)};
    foreach (plan[i]) begin
      set_term(16'(plan[i]));
      steady = ($urandom_range(0, 3) == 0);
      run_mix(70);
    end

    // widest term: press and release well inside it, tap left pending
    set_term(16'hffff);
    steady = 1'b1;
    send_key(CMD_PRESS);
    send_ticks(3);
    send_motions(2);
    send_key(CMD_RELEASE);
    send_motions(2);

    set_term(16'($urandom_range(1, 20)));
    steady = 1'b0;
    run_mix(40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d items: %0d motion, %0d press, %0d release, %0d tick", sent_total,
             sent_by_cmd[CMD_MOTION], sent_by_cmd[CMD_PRESS], sent_by_cmd[CMD_RELEASE],
             sent_by_cmd[CMD_TICK]);
    $display("%0d tapping-term settings from zero to 65535; %0d failures", n_terms, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
